>>> src/gelu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared widths, Q30 constants, stage payload types and fixed-point helpers
// for the erf-form GELU pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

    localparam int DATA_WIDTH = 24;
    localparam int FRAC_BITS  = 16;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

    // restoring divider depth, one quotient bit per stage
    localparam int DIV_N = 31;
    // exp / polynomial stages
    localparam int ERF_N = 8;

    localparam logic [31:0] ONE_Q30       = 32'd1073741824;
    localparam logic [31:0] HALF_Q30      = 32'd536870912;
    localparam logic [31:0] SIXTH_Q30     = 32'd178956971;
    localparam logic [31:0] T24_Q30       = 32'd44739243;
    localparam logic [31:0] LN2_Q30       = 32'd744261118;
    localparam logic [31:0] P_Q30         = 32'd351748265;
    localparam logic [31:0] INV_SQRT2_Q30 = 32'd759250125;
    localparam logic [31:0] EXP_ROOT_Q30  = 32'd911952339;
    localparam logic [63:0] Z_LIMIT_Q28   = 64'd6 << 28;

    localparam logic signed [33:0] A1_Q30 = 34'sd273621191;
    localparam logic signed [33:0] A2_Q30 = -34'sd305476044;
    localparam logic signed [33:0] A3_Q30 = 34'sd1526231383;
    localparam logic signed [33:0] A4_Q30 = -34'sd1560310108;
    localparam logic signed [33:0] A5_Q30 = 34'sd1139675401;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic                  neg;
        logic [DATA_WIDTH-1:0] ax;
        logic                  big;
        logic [35:0]           u;
        logic [29:0]           d;
    } front_t;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic                  neg;
        logic [DATA_WIDTH-1:0] ax;
        logic                  big;
        logic [35:0]           u;
        logic [30:0]           t;
    } div_t;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic                  neg;
        logic [DATA_WIDTH-1:0] ax;
        logic [30:0]           erfa;
    } erf_t;

    // unsigned Q30 product, round half up
    function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'd536870912;
        return p[61:30];
    endfunction

    // signed by non-negative Q30 product, rounded on the magnitude
    function automatic logic signed [33:0] smul30(input logic signed [33:0] a,
                                                  input logic [31:0] b);
        logic [33:0] ma;
        logic [65:0] p;
        logic [33:0] m;
        ma = a[33] ? 34'(-a) : 34'(a);
        p  = 66'(ma) * 66'(b) + 66'd536870912;
        m  = p[63:30];
        return a[33] ? -$signed(m) : $signed(m);
    endfunction

    // 2^-(i/8) in Q30
    function automatic logic [31:0] pow2_tbl(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'd1073741824;
            3'd1:    r = 32'd984625594;
            3'd2:    r = 32'd902905651;
            3'd3:    r = 32'd827968132;
            3'd4:    r = 32'd759250125;
            3'd5:    r = 32'd696235434;
            3'd6:    r = 32'd638450708;
            default: r = 32'd585461881;
        endcase
        return r;
    endfunction

endpackage

>>> src/gelu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_front
// Three stages: magnitude, scaled arguments z and v, then the exp exponent u
// and the divisor d = 1 + p*z.
// ----------------------------------------------------------------------------
module gelu_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [gelu_pkg::DATA_WIDTH-1:0] x,
    input  logic                            in_last,
    output gelu_pkg::front_t                f_o
);

    logic                            a_vld_reg;
    logic                            a_last_reg;
    logic                            a_neg_reg;
    logic [gelu_pkg::DATA_WIDTH-1:0] a_ax_reg;

    logic                            b_vld_reg;
    logic                            b_last_reg;
    logic                            b_neg_reg;
    logic [gelu_pkg::DATA_WIDTH-1:0] b_ax_reg;
    logic                            b_big_reg;
    logic [30:0]                     b_z_reg;
    logic [30:0]                     b_v_reg;

    gelu_pkg::front_t                c_reg;
    gelu_pkg::front_t                c_next;

    logic                            a_neg_next;
    logic [gelu_pkg::DATA_WIDTH-1:0] a_ax_next;
    logic [63:0]                     rnd;
    logic [63:0]                     z_full;
    logic [63:0]                     v_full;
    logic [63:0]                     vv;
    logic [63:0]                     pz;

    assign a_neg_next = x[gelu_pkg::DATA_WIDTH-1];
    assign a_ax_next  = a_neg_next ? gelu_pkg::DATA_WIDTH'(-x) : x;

    assign rnd    = 64'd1 << (gelu_pkg::FRAC_BITS + 1);
    assign z_full = (64'(a_ax_reg) * 64'(gelu_pkg::INV_SQRT2_Q30) + rnd)
                    >> (gelu_pkg::FRAC_BITS + 2);
    assign v_full = (64'(a_ax_reg) * 64'(gelu_pkg::EXP_ROOT_Q30) + rnd)
                    >> (gelu_pkg::FRAC_BITS + 2);

    assign vv = 64'(b_v_reg) * 64'(b_v_reg) + 64'd33554432;
    assign pz = 64'(gelu_pkg::P_Q30) * 64'(b_z_reg) + 64'd536870912;

    always_comb begin
        c_next      = '0;
        c_next.vld  = b_vld_reg;
        c_next.last = b_last_reg;
        c_next.neg  = b_neg_reg;
        c_next.ax   = b_ax_reg;
        c_next.big  = b_big_reg;
        c_next.u    = vv[61:26];
        c_next.d    = 30'(64'd268435456 + (pz >> 30));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_reg.vld <= 1'b0;
        end else if (en) begin
            a_vld_reg  <= in_vld;
            a_last_reg <= in_last;
            a_neg_reg  <= a_neg_next;
            a_ax_reg   <= a_ax_next;

            b_vld_reg  <= a_vld_reg;
            b_last_reg <= a_last_reg;
            b_neg_reg  <= a_neg_reg;
            b_ax_reg   <= a_ax_reg;
            b_big_reg  <= (z_full >= gelu_pkg::Z_LIMIT_Q28);
            b_z_reg    <= z_full[30:0];
            b_v_reg    <= v_full[30:0];

            c_reg      <= c_next;
        end
    end

    assign f_o = c_reg;

endmodule

>>> src/gelu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_div
// Pipelined restoring divider, t = round(2^58 / d), one quotient bit per
// stage; the rest of the item rides along with each stage.
// ----------------------------------------------------------------------------
module gelu_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  gelu_pkg::front_t f_i,
    output gelu_pkg::div_t   d_o
);

    gelu_pkg::front_t f_reg   [gelu_pkg::DIV_N];
    logic [29:0]      rem_reg [gelu_pkg::DIV_N];
    logic [30:0]      q_reg   [gelu_pkg::DIV_N];

    genvar i;
    generate
        for (i = 0; i < gelu_pkg::DIV_N; i++) begin : g_stage
            gelu_pkg::front_t f_src;
            logic [29:0]      rem_src;
            logic [30:0]      q_src;
            logic [30:0]      nlow;
            logic [30:0]      trial;
            logic             fits;
            logic [29:0]      rem_next;
            logic [30:0]      q_next;

            if (i == 0) begin : g_first
                // numerator 2^58 + d/2: high part is always 2^27
                assign f_src   = f_i;
                assign rem_src = 30'h0800_0000;
                assign q_src   = '0;
            end else begin : g_rest
                assign f_src   = f_reg[i-1];
                assign rem_src = rem_reg[i-1];
                assign q_src   = q_reg[i-1];
            end

            assign nlow     = {2'b00, f_src.d[29:1]};
            assign trial    = {rem_src, nlow[gelu_pkg::DIV_N-1-i]};
            assign fits     = (trial >= {1'b0, f_src.d});
            assign rem_next = fits ? 30'(trial - {1'b0, f_src.d}) : trial[29:0];
            assign q_next   = {q_src[29:0], fits};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    f_reg[i].vld <= 1'b0;
                end else if (en) begin
                    f_reg[i]   <= f_src;
                    rem_reg[i] <= rem_next;
                    q_reg[i]   <= q_next;
                end
            end
        end
    endgenerate

    always_comb begin
        d_o      = '0;
        d_o.vld  = f_reg[gelu_pkg::DIV_N-1].vld;
        d_o.last = f_reg[gelu_pkg::DIV_N-1].last;
        d_o.neg  = f_reg[gelu_pkg::DIV_N-1].neg;
        d_o.ax   = f_reg[gelu_pkg::DIV_N-1].ax;
        d_o.big  = f_reg[gelu_pkg::DIV_N-1].big;
        d_o.u    = f_reg[gelu_pkg::DIV_N-1].u;
        d_o.t    = q_reg[gelu_pkg::DIV_N-1];
    end

endmodule

>>> src/gelu_erf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_expoly
// Eight stages: 2^-u by table and Taylor polynomial side by side with the
// Horner polynomial in t, then erf = 1 - poly*exp with clamping.
// ----------------------------------------------------------------------------
module gelu_expoly (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gelu_pkg::div_t d_i,
    output gelu_pkg::erf_t e_o
);

    typedef struct packed {
        logic                            vld;
        logic                            last;
        logic                            neg;
        logic [gelu_pkg::DATA_WIDTH-1:0] ax;
        logic                            big;
        logic [30:0]                     t;
        logic [26:0]                     s;
        logic [2:0]                      idx;
        logic [4:0]                      n;
        logic                            tiny;
        logic [31:0]                     q;
        logic signed [33:0]              p;
        logic [31:0]                     e;
    } erf_st_t;

    erf_st_t st_reg  [gelu_pkg::ERF_N];
    erf_st_t st_next [gelu_pkg::ERF_N];

    always_comb begin
        logic [31:0]        s_full;
        logic signed [33:0] m;
        logic signed [34:0] ev;

        s_full = gelu_pkg::umul30(32'(d_i.u[26:0]), gelu_pkg::LN2_Q30);

        st_next[0]      = '0;
        st_next[0].vld  = d_i.vld;
        st_next[0].last = d_i.last;
        st_next[0].neg  = d_i.neg;
        st_next[0].ax   = d_i.ax;
        st_next[0].big  = d_i.big;
        st_next[0].t    = d_i.t;
        st_next[0].s    = s_full[26:0];
        st_next[0].idx  = d_i.u[29:27];
        st_next[0].n    = d_i.u[34:30];
        st_next[0].tiny = (d_i.u[35:30] >= 6'd31);
        st_next[0].p    = gelu_pkg::smul30(gelu_pkg::A5_Q30, 32'(d_i.t)) + gelu_pkg::A4_Q30;

        st_next[1]   = st_reg[0];
        st_next[1].q = gelu_pkg::SIXTH_Q30
                       - gelu_pkg::umul30(32'(st_reg[0].s), gelu_pkg::T24_Q30);
        st_next[1].p = gelu_pkg::smul30(st_reg[0].p, 32'(st_reg[0].t)) + gelu_pkg::A3_Q30;

        st_next[2]   = st_reg[1];
        st_next[2].q = gelu_pkg::HALF_Q30
                       - gelu_pkg::umul30(32'(st_reg[1].s), st_reg[1].q);
        st_next[2].p = gelu_pkg::smul30(st_reg[1].p, 32'(st_reg[1].t)) + gelu_pkg::A2_Q30;

        st_next[3]   = st_reg[2];
        st_next[3].q = gelu_pkg::ONE_Q30
                       - gelu_pkg::umul30(32'(st_reg[2].s), st_reg[2].q);
        st_next[3].p = gelu_pkg::smul30(st_reg[2].p, 32'(st_reg[2].t)) + gelu_pkg::A1_Q30;

        st_next[4]   = st_reg[3];
        st_next[4].q = gelu_pkg::ONE_Q30
                       - gelu_pkg::umul30(32'(st_reg[3].s), st_reg[3].q);
        st_next[4].p = gelu_pkg::smul30(st_reg[3].p, 32'(st_reg[3].t));

        st_next[5]   = st_reg[4];
        st_next[5].e = gelu_pkg::umul30(gelu_pkg::pow2_tbl(st_reg[4].idx), st_reg[4].q);

        // integer part of u is a rounding right shift
        st_next[6] = st_reg[5];
        if (st_reg[5].tiny) begin
            st_next[6].e = '0;
        end else if (st_reg[5].n != 5'd0) begin
            st_next[6].e = (st_reg[5].e + (32'd1 << 5'(st_reg[5].n - 5'd1))) >> st_reg[5].n;
        end

        m  = gelu_pkg::smul30(st_reg[6].p, st_reg[6].e);
        ev = $signed({3'b000, gelu_pkg::ONE_Q30}) - 35'(m);
        st_next[7] = st_reg[6];
        if (st_reg[6].big) begin
            st_next[7].e = gelu_pkg::ONE_Q30;
        end else if (ev < 0) begin
            st_next[7].e = '0;
        end else if (ev > $signed({3'b000, gelu_pkg::ONE_Q30})) begin
            st_next[7].e = gelu_pkg::ONE_Q30;
        end else begin
            st_next[7].e = 32'(ev);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < gelu_pkg::ERF_N; k++) begin
            if (!aresetn) begin
                st_reg[k].vld <= 1'b0;
            end else if (en) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_comb begin
        e_o      = '0;
        e_o.vld  = st_reg[gelu_pkg::ERF_N-1].vld;
        e_o.last = st_reg[gelu_pkg::ERF_N-1].last;
        e_o.neg  = st_reg[gelu_pkg::ERF_N-1].neg;
        e_o.ax   = st_reg[gelu_pkg::ERF_N-1].ax;
        e_o.erfa = st_reg[gelu_pkg::ERF_N-1].e[30:0];
    end

endmodule

>>> src/gelu_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_out
// Final scale y = x*(1+erf)/2 with sign restore, then the output register
// and a one-entry skid buffer that drives the pipeline advance.
// ----------------------------------------------------------------------------
module gelu_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gelu_pkg::erf_t                e_i,
    input  logic                          m_tready,
    output logic                          en,
    output logic                          m_tvalid,
    output logic [gelu_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    logic                            y_vld_reg;
    logic                            y_last_reg;
    logic [gelu_pkg::DATA_WIDTH-1:0] y_reg;

    logic                            o_vld_reg;
    logic                            o_last_reg;
    logic [gelu_pkg::DATA_WIDTH-1:0] o_y_reg;

    logic                            k_vld_reg;
    logic                            k_last_reg;
    logic [gelu_pkg::DATA_WIDTH-1:0] k_y_reg;

    logic [31:0]                     g;
    logic [63:0]                     prod;
    logic [gelu_pkg::DATA_WIDTH-1:0] ym;
    logic [gelu_pkg::DATA_WIDTH-1:0] y_next;
    logic                            push;

    assign g      = e_i.neg ? gelu_pkg::ONE_Q30 - 32'(e_i.erfa)
                            : gelu_pkg::ONE_Q30 + 32'(e_i.erfa);
    assign prod   = 64'(e_i.ax) * 64'(g) + 64'(gelu_pkg::ONE_Q30);
    assign ym     = gelu_pkg::DATA_WIDTH'(prod >> 31);
    assign y_next = e_i.neg ? gelu_pkg::DATA_WIDTH'(-ym) : ym;

    assign en   = ~k_vld_reg;
    assign push = en & y_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_vld_reg <= 1'b0;
        end else if (en) begin
            y_vld_reg  <= e_i.vld;
            y_last_reg <= e_i.last;
            y_reg      <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end else if (k_vld_reg) begin
            if (m_tready) begin
                o_y_reg    <= k_y_reg;
                o_last_reg <= k_last_reg;
                k_vld_reg  <= 1'b0;
            end
        end else if (push) begin
            if (!o_vld_reg || m_tready) begin
                o_y_reg    <= y_reg;
                o_last_reg <= y_last_reg;
                o_vld_reg  <= 1'b1;
            end else begin
                // output still held, park the item
                k_y_reg    <= y_reg;
                k_last_reg <= y_last_reg;
                k_vld_reg  <= 1'b1;
            end
        end else if (m_tready) begin
            o_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = gelu_pkg::TDATA_W'(o_y_reg);
    assign m_tlast  = o_last_reg;

endmodule

>>> src/gelu_erf_activation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_erf_activation_core
// Exact-form GELU, y = 0.5*x*(1+erf(x/sqrt2)), signed fixed point in and out.
// ----------------------------------------------------------------------------
// pipeline from input accept to m_tvalid: 3 front, 31 divider, 8 exp/polynomial
//   stages, then 1 scale register and 1 output register
// throughput: one item per cycle unless the skid is full; set by the bit-per-stage divider
// a one-entry skid keeps s_tready high while a result waits on m_tready, until it fills
// reset: synchronous active-low aresetn clears all stage valid bits and the
//   output and skid valid bits; s_tready is high right after reset
module gelu_erf_activation_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gelu_pkg::TDATA_W-1:0] s_tdata,  // [23:0] x_in
    input  logic                         s_tlast,  // in_last
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gelu_pkg::TDATA_W-1:0] m_tdata,  // [23:0] y_out
    output logic                         m_tlast   // out_last
);

    logic             en;
    gelu_pkg::front_t f_s;
    gelu_pkg::div_t   d_s;
    gelu_pkg::erf_t   e_s;

    assign s_tready = en;

    gelu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .x       (s_tdata[gelu_pkg::DATA_WIDTH-1:0]),
        .in_last (s_tlast),
        .f_o     (f_s)
    );

    gelu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .f_i     (f_s),
        .d_o     (d_s)
    );

    gelu_expoly u_erf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_i     (d_s),
        .e_o     (e_s)
    );

    gelu_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .e_i      (e_s),
        .m_tready (m_tready),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> src/gelu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_chk
// Port-level checks on the stream handshakes and the skid behavior.
// ----------------------------------------------------------------------------
module gelu_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [gelu_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tlast
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata changed while stalled");

    // input backpressure only when a result is parked
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // parked item drains as soon as the output is taken
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready && m_tvalid)
        else $error("skid did not drain");

endmodule

bind gelu_erf_activation_core gelu_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/tb_gelu_erf_activation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gelu_erf_activation_core
// Streams activation values through the GELU core and checks every result
// against a bit-exact fixed-point predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_gelu_erf_activation_core;

    localparam int LIMIT = 400000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gelu_pkg::TDATA_W-1:0]   s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gelu_pkg::TDATA_W-1:0]   m_tdata;
    logic                           m_tlast;

    typedef struct packed {
        logic [gelu_pkg::DATA_WIDTH-1:0] y;
        logic                            last;
    } gelu_res_t;

    gelu_res_t      gelu_q[$];
    int             mismatches;
    int             results_seen;
    int             items_sent;
    int             cycles;
    bit             rx_stall_on;

    gelu_erf_activation_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint q30_smul(longint a, longint b);
        bit             neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = q30_mul(ma, mb);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned exp2_neg(longint unsigned u);
        longint unsigned n, f, r, s, q, e;
        logic [31:0]     tbl [8];
        tbl = '{32'd1073741824, 32'd984625594, 32'd902905651, 32'd827968132,
                32'd759250125, 32'd696235434, 32'd638450708, 32'd585461881};
        n = u >> 30;
        f = u & ((64'd1 << 30) - 1);
        r = f & ((64'd1 << 27) - 1);
        if (n >= 31) return 0;
        s = q30_mul(r, 744261118);
        q = 178956971 - q30_mul(s, 44739243);
        q = 536870912 - q30_mul(s, q);
        q = 1073741824 - q30_mul(s, q);
        q = 1073741824 - q30_mul(s, q);
        e = q30_mul(tbl[(f >> 27) & 7], q);
        if (n > 0) e = (e + (64'd1 << (n - 1))) >> n;
        return e;
    endfunction

    function automatic longint unsigned erf_mag(longint unsigned ax);
        longint unsigned rnd, z, v, u, d, t, e;
        longint          poly, erfv;
        rnd = 64'd1 << (gelu_pkg::FRAC_BITS + 1);
        z = (ax * 759250125 + rnd) >> (gelu_pkg::FRAC_BITS + 2);
        if (z >= (64'd6 << 28)) return 64'd1 << 30;
        v = (ax * 911952339 + rnd) >> (gelu_pkg::FRAC_BITS + 2);
        u = (v * v + (64'd1 << 25)) >> 26;
        e = exp2_neg(u);
        d = (64'd1 << 28) + ((64'd351748265 * z + (64'd1 << 29)) >> 30);
        t = ((64'd1 << 58) + (d >> 1)) / d;
        poly = 1139675401;
        poly = q30_smul(poly, t) - 1560310108;
        poly = q30_smul(poly, t) + 1526231383;
        poly = q30_smul(poly, t) - 305476044;
        poly = q30_smul(poly, t) + 273621191;
        poly = q30_smul(poly, t);
        erfv = (64'sd1 <<< 30) - q30_smul(poly, e);
        if (erfv < 0) erfv = 0;
        if (erfv > (64'sd1 <<< 30)) erfv = 64'sd1 <<< 30;
        return erfv;
    endfunction

    function automatic gelu_res_t predict_gelu(logic [gelu_pkg::DATA_WIDTH-1:0] x,
                                               logic last);
        gelu_res_t                       r;
        logic [gelu_pkg::DATA_WIDTH-1:0] axv;
        longint unsigned                 ax, ea, g, ym;
        axv = x[gelu_pkg::DATA_WIDTH-1] ? -x : x;
        ax  = (x == {1'b1, {(gelu_pkg::DATA_WIDTH-1){1'b0}}}) ?
              (64'd1 << (gelu_pkg::DATA_WIDTH-1)) : axv;
        ea  = erf_mag(ax);
        g   = x[gelu_pkg::DATA_WIDTH-1] ? (64'd1 << 30) - ea : (64'd1 << 30) + ea;
        ym  = (ax * g + (64'd1 << 30)) >> 31;
        r.y    = x[gelu_pkg::DATA_WIDTH-1] ? -ym[gelu_pkg::DATA_WIDTH-1:0]
                                           : ym[gelu_pkg::DATA_WIDTH-1:0];
        r.last = last;
        return r;
    endfunction

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [gelu_pkg::DATA_WIDTH-1:0] x, logic last);
        int gap;
        gap = pick_gap();
        // drop valid during the gap so the previous item is not taken twice
        if (gap != 0) s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= gelu_pkg::TDATA_W'(x);
        s_tlast  <= last;
        gelu_q.push_back(predict_gelu(x, last));
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
    endtask

    // receiver stalls, with quiet stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            rx_stall_on <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_stall_on <= ~rx_stall_on;
            if (!rx_stall_on) m_tready <= 1'b1;
            else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        gelu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (gelu_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = gelu_q.pop_front();
                if (m_tdata[gelu_pkg::DATA_WIDTH-1:0] !== want.y || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: y exp %h got %h, last exp %b got %b",
                                 want.y, m_tdata[gelu_pkg::DATA_WIDTH-1:0], want.last,
                                 m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [gelu_pkg::DATA_WIDTH-1:0] vals [$];
        vals = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h800001,
                 24'h010000, 24'hFF0000, 24'h020000, 24'hFE0000, 24'h008000, 24'hFF8000,
                 24'h087000, 24'hF79000, 24'h050000, 24'hFB0000, 24'h000010, 24'hFFFFF0,
                 24'h555555, 24'hAAAAAA, 24'h040000, 24'hFC0000};
        foreach (vals[i]) send_item(vals[i], i[0]);
        drop_valid();
    endtask

    task automatic test_random();
        logic [gelu_pkg::DATA_WIDTH-1:0] x;
        for (int i = 0; i < 1000; i++) begin
            case ($urandom_range(0, 3))
                0: x = gelu_pkg::DATA_WIDTH'($urandom);
                1: x = gelu_pkg::DATA_WIDTH'($signed($urandom_range(0, 8 << 16)) -
                                             $signed(4 << 16));
                2: x = gelu_pkg::DATA_WIDTH'($signed($urandom_range(0, 1024)) - 512);
                default: x = gelu_pkg::DATA_WIDTH'($signed($urandom_range(0, 16 << 16)) -
                                                   $signed(8 << 16));
            endcase
            send_item(x, $urandom_range(0, 7) == 0);
        end
        drop_valid();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        cycles     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        while (gelu_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("sent %0d items, checked %0d results: field extremes, saturation and",
                 items_sent, results_seen);
        $display("erf-region values under random source gaps and sink stalls");
        if (mismatches == 0 && gelu_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> gelu_erf_activation_core.f
src/gelu_pkg.sv
src/gelu_front.sv
src/gelu_div.sv
src/gelu_erf.sv
src/gelu_out.sv
src/gelu_erf_activation_core.sv
src/gelu_chk.sv
bench/tb_gelu_erf_activation_core.sv
